// ===== rtl/pmst_pkg.sv =====
// Shared types, codes and constants for the pending message state table.
`default_nettype none
package pmst_pkg;

   localparam int PMST_BUCKET_COUNT = 1024;
   localparam int PMST_WAYS = 4;
   localparam int PMST_STATE_BITS = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int HASH_BITS = 32;
   localparam int COUNT_BITS = 13;
   localparam logic [31:0] EXPIRY_RESET = 32'd30;

   localparam logic [2:0] FUNC_UPDATE = 3'd0;
   localparam logic [2:0] FUNC_GET = 3'd1;
   localparam logic [2:0] FUNC_REMOVE = 3'd2;
   localparam logic [2:0] FUNC_SWEEP = 3'd3;
   localparam logic [2:0] FUNC_CLEAR = 3'd4;

   typedef enum logic [2:0] {
      OP_UPDATE,
      OP_GET,
      OP_REMOVE,
      OP_SWEEP,
      OP_CLEAR,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      ENG_INIT,
      ENG_IDLE,
      ENG_LOOK,
      ENG_SWEEP
   } eng_state_type;

   typedef struct packed {
      logic [2:0] func;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [31:0] message_id;
      logic [2:0] new_state;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic found;
      logic [2:0] state_out;
      logic bucket_full;
      logic [COUNT_BITS-1:0] expired_count;
   } rsp_type;

   typedef struct packed {
      op_type op;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic [31:0] message_id;
      logic [2:0] new_state;
      logic [31:0] now_seconds;
   } cmd_type;

endpackage
`default_nettype wire

// ===== rtl/pending_message_state_table.sv =====
// Top level of the pending message state table.
// Requests are keyed by peer address, port and message id and hashed to one bucket of
// WAYS slots; the bucket rows live in one RAM. Update, get and remove each pass through
// the table engine's idle and lookup states (one bucket row read, then its write-back),
// and the engine takes no new word while in lookup; a bucket count that is not a power
// of two adds hashing steps (quotient, difference, remainder) in the front end. An expiry
// sweep or a clear walks every bucket row. After reset the engine clears the RAM one row
// per cycle, and req_ready stays low until that pass is done. The expiry age register
// may be written at any time the block is idle.
`default_nettype none
module pending_message_state_table import pmst_pkg::*; #(
   parameter int BUCKET_COUNT = PMST_BUCKET_COUNT,
   parameter int WAYS = PMST_WAYS,
   parameter int STATE_BITS = PMST_STATE_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   localparam int BW = $clog2(BUCKET_COUNT);

   logic [31:0] expiry_ff;
   logic init_busy;
   logic push_valid, push_ready;
   cmd_type push_cmd, q_cmd;
   logic [BW-1:0] push_bucket, q_bucket;
   logic q_valid, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         expiry_ff <= EXPIRY_RESET;
      end else if (csr_wr_en) begin
         expiry_ff <= csr_wr_data;
      end
   end

   pmst_front #(
      .BUCKET_COUNT(BUCKET_COUNT)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .init_busy(init_busy),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_cmd(push_cmd),
      .push_bucket(push_bucket)
   );

   pmst_queue #(
      .BUCKET_COUNT(BUCKET_COUNT)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_cmd(push_cmd),
      .push_bucket(push_bucket),
      .q_valid(q_valid),
      .q_pop(q_pop),
      .q_cmd(q_cmd),
      .q_bucket(q_bucket)
   );

   pmst_engine #(
      .BUCKET_COUNT(BUCKET_COUNT),
      .WAYS(WAYS),
      .STATE_BITS(STATE_BITS)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .expiry(expiry_ff),
      .q_valid(q_valid),
      .q_pop(q_pop),
      .q_cmd(q_cmd),
      .q_bucket(q_bucket),
      .init_busy(init_busy),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire

// ===== rtl/pmst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pmst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/pmst_front.sv =====
// Front end: accepts request words, decodes the function and hashes the key to a bucket.
`default_nettype none
module pmst_front import pmst_pkg::*; #(
   parameter int BUCKET_COUNT = PMST_BUCKET_COUNT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire req_type                         req_data,
   input  wire logic                            init_busy,
   output logic                                 push_valid,
   input  wire logic                            push_ready,
   output cmd_type                              push_cmd,
   output logic [$clog2(BUCKET_COUNT)-1:0]      push_bucket
);

   localparam int BW = $clog2(BUCKET_COUNT);
   localparam int RW = BW + 1;
   localparam int PW = HASH_BITS + 33;
   localparam int SHIFT = HASH_BITS + BW;
   localparam bit IS_POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;
   localparam logic [RW-1:0] MODULUS = RW'(BUCKET_COUNT);
   localparam logic [32:0] RECIP = 33'((64'd1 << SHIFT) / 64'(BUCKET_COUNT));

   logic busy_ff, busy_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [HASH_BITS-1:0] hash_ff, hash_in;
   logic [HASH_BITS-1:0] quot_ff, quot_in;
   cmd_type cmd_ff, cmd_in;
   logic push, accept;
   logic [PW-1:0] prod;
   logic [HASH_BITS-1:0] diff;
   logic [HASH_BITS-1:0] hash_new;
   op_type op_dec;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      hash_ff <= hash_in;
      quot_ff <= quot_in;
      cmd_ff <= cmd_in;
   end

   always_comb begin
      unique case (req_data.func)
         FUNC_UPDATE: op_dec = OP_UPDATE;
         FUNC_GET:    op_dec = OP_GET;
         FUNC_REMOVE: op_dec = OP_REMOVE;
         FUNC_SWEEP:  op_dec = OP_SWEEP;
         FUNC_CLEAR:  op_dec = OP_CLEAR;
         default:     op_dec = OP_NONE;
      endcase
   end

   always_comb begin
      prod = PW'(hash_ff) * PW'(RECIP);
      diff = hash_ff - HASH_BITS'(quot_ff * HASH_BITS'(BUCKET_COUNT));
   end

   always_comb begin
      push_valid = busy_ff && (cnt_ff == '0);
      push = push_valid && push_ready;
      req_ready = !init_busy && (!busy_ff || push);
      accept = req_valid && req_ready;
      push_cmd = cmd_ff;
      push_bucket = rem_ff[BW-1:0];
      hash_new = req_data.peer_ip ^ {16'b0, req_data.peer_port} ^ req_data.message_id;
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      hash_in = hash_ff;
      quot_in = quot_ff;
      cmd_in = cmd_ff;
      if (busy_ff && (cnt_ff != '0)) begin
         cnt_in = cnt_ff - 1'b1;
         case (cnt_ff)
            2'd3: quot_in = HASH_BITS'(prod >> SHIFT);
            2'd2: hash_in = diff;
            default: begin
               rem_in = (hash_ff[RW-1:0] >= MODULUS) ? hash_ff[RW-1:0] - MODULUS
                                                     : hash_ff[RW-1:0];
            end
         endcase
      end
      if (push) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
         cmd_in.op = op_dec;
         cmd_in.peer_ip = req_data.peer_ip;
         cmd_in.peer_port = req_data.peer_port;
         cmd_in.message_id = req_data.message_id;
         cmd_in.new_state = req_data.new_state;
         cmd_in.now_seconds = req_data.now_seconds;
         hash_in = hash_new;
         rem_in = IS_POW2 ? {1'b0, hash_new[BW-1:0]} : '0;
         cnt_in = IS_POW2 ? 2'd0 : 2'd3;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/pmst_queue.sv =====
// Short command queue between the front end and the table engine.
`default_nettype none
module pmst_queue import pmst_pkg::*; #(
   parameter int BUCKET_COUNT = PMST_BUCKET_COUNT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push_valid,
   output logic                                 push_ready,
   input  wire cmd_type                         push_cmd,
   input  wire logic [$clog2(BUCKET_COUNT)-1:0] push_bucket,
   output logic                                 q_valid,
   input  wire logic                            q_pop,
   output cmd_type                              q_cmd,
   output logic [$clog2(BUCKET_COUNT)-1:0]      q_bucket
);

   localparam int BW = $clog2(BUCKET_COUNT);
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   cmd_type cmd_ff [QUEUE_DEPTH];
   logic [BW-1:0] bucket_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0] count_ff;
   logic push, pop;

   assign push_ready = count_ff != NW'(QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign push = push_valid && push_ready;
   assign pop = q_pop && q_valid;
   assign q_cmd = cmd_ff[rd_ptr_ff];
   assign q_bucket = bucket_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + NW'(push) - NW'(pop);
      end
      if (push) begin
         cmd_ff[wr_ptr_ff] <= push_cmd;
         bucket_ff[wr_ptr_ff] <= push_bucket;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/pmst_engine.sv =====
// Table engine: bucket read-modify-write, table sweeps, reset clearing and the result register.
`default_nettype none
module pmst_engine import pmst_pkg::*; #(
   parameter int BUCKET_COUNT = PMST_BUCKET_COUNT,
   parameter int WAYS = PMST_WAYS,
   parameter int STATE_BITS = PMST_STATE_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [31:0]                     expiry,
   input  wire logic                            q_valid,
   output logic                                 q_pop,
   input  wire cmd_type                         q_cmd,
   input  wire logic [$clog2(BUCKET_COUNT)-1:0] q_bucket,
   output logic                                 init_busy,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output rsp_type                              rsp_data
);

   localparam int BW = $clog2(BUCKET_COUNT);
   localparam int EW = 113 + STATE_BITS;
   localparam int ROW_W = WAYS * EW;
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int PCW = $clog2(WAYS + 1);
   localparam logic [BW-1:0] LAST_ROW = BW'(BUCKET_COUNT - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   eng_state_type state_ff, state_in;
   logic [BW-1:0] row_ff, row_in;
   cmd_type cmd_ff, cmd_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic ram_we, ram_re;
   logic [BW-1:0] ram_wr_addr, ram_rd_addr;
   logic [ROW_W-1:0] ram_wr_data, ram_rd_data;

   logic [WAYS-1:0] match, free, drop;
   logic [WW-1:0] hit_idx, free_idx;
   logic [PCW-1:0] drop_cnt;
   logic [COUNT_BITS:0] count_sum;
   logic [COUNT_BITS-1:0] count_next;
   logic [ROW_W-1:0] upd_row, drop_row;
   logic [EW-1:0] fresh_slot;
   logic [STATE_BITS-1:0] hit_state;

   pmst_ram #(
      .WIDTH(ROW_W),
      .DEPTH(BUCKET_COUNT)
   ) u_ram (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en(ram_re),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_INIT;
         row_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      count_ff <= count_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      match = '0;
      free = '0;
      drop = '0;
      hit_idx = '0;
      free_idx = '0;
      drop_cnt = '0;
      for (int w = 0; w < WAYS; w++) begin
         free[w] = !ram_rd_data[w*EW + EW - 1];
         match[w] = !free[w]
            && (ram_rd_data[w*EW + 80 + STATE_BITS +: 32] == cmd_ff.peer_ip)
            && (ram_rd_data[w*EW + 64 + STATE_BITS +: 16] == cmd_ff.peer_port)
            && (ram_rd_data[w*EW + 32 + STATE_BITS +: 32] == cmd_ff.message_id);
         drop[w] = !free[w] && ((cmd_ff.op == OP_CLEAR)
            || ((cmd_ff.now_seconds - ram_rd_data[w*EW +: 32]) > expiry));
         drop_cnt = drop_cnt + PCW'(drop[w]);
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_idx = WW'(w);
         end
         if (free[w]) begin
            free_idx = WW'(w);
         end
      end
      fresh_slot = {1'b1, cmd_ff.peer_ip, cmd_ff.peer_port, cmd_ff.message_id,
                    STATE_BITS'(cmd_ff.new_state), cmd_ff.now_seconds};
      hit_state = ram_rd_data[hit_idx*EW + 32 +: STATE_BITS];
      upd_row = ram_rd_data;
      if (|match) begin
         upd_row[hit_idx*EW +: EW] = fresh_slot;
      end else begin
         upd_row[free_idx*EW +: EW] = fresh_slot;
      end
      drop_row = ram_rd_data;
      for (int w = 0; w < WAYS; w++) begin
         if (drop[w]) begin
            drop_row[w*EW + EW - 1] = 1'b0;
         end
      end
      count_sum = {1'b0, count_ff} + (COUNT_BITS + 1)'(drop_cnt);
      count_next = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : count_sum[COUNT_BITS-1:0];
   end

   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      cmd_in = cmd_ff;
      count_in = count_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop = 1'b0;
      ram_we = 1'b0;
      ram_re = 1'b0;
      ram_wr_addr = row_ff;
      ram_rd_addr = row_ff;
      ram_wr_data = ram_rd_data;
      unique case (state_ff)
         ENG_INIT: begin
            ram_we = 1'b1;
            ram_wr_data = '0;
            row_in = row_ff + 1'b1;
            if (row_ff == LAST_ROW) begin
               row_in = '0;
               state_in = ENG_IDLE;
            end
         end
         ENG_IDLE: begin
            if (q_valid && (!rsp_valid_ff || rsp_ready)) begin
               q_pop = 1'b1;
               cmd_in = q_cmd;
               count_in = '0;
               case (q_cmd.op)
                  OP_NONE: begin
                     rsp_in = '0;
                     rsp_valid_in = 1'b1;
                  end
                  OP_SWEEP, OP_CLEAR: begin
                     ram_re = 1'b1;
                     ram_rd_addr = '0;
                     row_in = '0;
                     state_in = ENG_SWEEP;
                  end
                  default: begin
                     ram_re = 1'b1;
                     ram_rd_addr = q_bucket;
                     row_in = q_bucket;
                     state_in = ENG_LOOK;
                  end
               endcase
            end
         end
         ENG_LOOK: begin
            rsp_in = '0;
            rsp_in.found = |match;
            rsp_valid_in = 1'b1;
            state_in = ENG_IDLE;
            case (cmd_ff.op)
               OP_UPDATE: begin
                  ram_wr_data = upd_row;
                  ram_we = (|match) || (|free);
                  rsp_in.bucket_full = !(|match) && !(|free);
               end
               OP_GET: begin
                  rsp_in.state_out = (|match) ? 3'(hit_state) : 3'b0;
               end
               default: begin
                  ram_wr_data = ram_rd_data;
                  ram_wr_data[hit_idx*EW + EW - 1] = 1'b0;
                  ram_we = |match;
               end
            endcase
         end
         ENG_SWEEP: begin
            ram_we = 1'b1;
            ram_wr_data = drop_row;
            count_in = count_next;
            if (row_ff == LAST_ROW) begin
               rsp_in = '0;
               rsp_in.expired_count = count_next;
               rsp_valid_in = 1'b1;
               state_in = ENG_IDLE;
            end else begin
               row_in = row_ff + 1'b1;
               ram_re = 1'b1;
               ram_rd_addr = row_ff + 1'b1;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   assign init_busy = state_ff == ENG_INIT;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ENG_IDLE) |-> !ram_we)
      else $error("table written while idle");

   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!rsp_valid_ff || rsp_ready))
      else $error("command taken while result register is held");

   a_init_no_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ENG_INIT) |-> !q_pop)
      else $error("command taken during clearing pass");

   a_look_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ENG_LOOK) |=> (state_ff == ENG_IDLE && rsp_valid_ff))
      else $error("bucket lookup did not finish with a result");

endmodule
`default_nettype wire
